/* sv/iasv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iasv_pkg
// Shared constants, kind codes and the flag bundle of the arc segment
// validator pipeline.
// ----------------------------------------------------------------------------
package iasv_pkg;

    // Coordinate span in nanometres, both signs
    localparam logic [63:0] SPAN_NM  = 64'd1000000000000;
    localparam logic [63:0] SPAN2_NM = 64'd2000000000000;

    // Differences of in-span values fit a 42-bit signed operand
    localparam int OPW  = 42;
    localparam int HALF = OPW / 2;
    localparam int PPW  = 2 * (HALF + 1);
    localparam int MIDW = PPW + 1;
    localparam int PW   = 86;

    // Curve kind codes
    localparam logic [1:0] KIND_LINE = 2'd0;
    localparam logic [1:0] KIND_ARC  = 2'd1;

    // Product slots of the multiplier bank
    localparam int NMUL    = 9;
    localparam int MUL_AXAX = 0;
    localparam int MUL_AYAY = 1;
    localparam int MUL_BXBX = 2;
    localparam int MUL_BYBY = 3;
    localparam int MUL_RR   = 4;
    localparam int MUL_AXBY = 5;
    localparam int MUL_AYBX = 6;
    localparam int MUL_AXBX = 7;
    localparam int MUL_AYBY = 8;

    // Decisions made at the front, carried down the pipe
    typedef struct packed {
        logic base_ok;   // id nonzero, endpoints in span and distinct
        logic is_line;
        logic is_arc;
        logic arc_ok;    // radius 1..span, center in span
        logic ccw;
        logic major;
    } flags_t;

    // True when a two's complement value lies within plus or minus the span
    function automatic logic in_span(input logic [63:0] v);
        logic [63:0] t;
        t = v + SPAN_NM;
        return t <= SPAN2_NM;
    endfunction

endpackage

/* sv/integer_arc_segment_validator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_arc_segment_validator_unit
// Checks one curve record per word: span, endpoint, radius, on-circle and
// orientation tests with exact 86-bit products, five register stages.
// ----------------------------------------------------------------------------
// Done: the valid bit of an accepted word passes v1_reg, v2_reg, v3_reg, v4_reg and done_reg, in that order.
// Throughput: one word per cycle; busy is always low and the pipe never stalls.
// The rate is set by the five-stage pipeline around the split 42-bit multipliers.
// Reset: rst_n clears all stage valid bits and done; words in flight are lost.
module integer_arc_segment_validator_unit
    import iasv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        curve_id,
    input  logic [1:0]         curve_kind,
    input  logic signed [63:0] start_x,
    input  logic signed [63:0] start_y,
    input  logic signed [63:0] end_x,
    input  logic signed [63:0] end_y,
    input  logic signed [63:0] center_x,
    input  logic signed [63:0] center_y,
    input  logic [63:0]        radius,
    input  logic               ccw,
    input  logic               major,
    output logic               done,
    output logic               valid_res
);

    // ------------------------------------------------------------------
    // Stage 1: range checks and differences about the center
    // ------------------------------------------------------------------
    logic               v1_reg;
    flags_t             f1_reg;
    flags_t             f1_next;
    logic signed [OPW-1:0] ax_reg, ay_reg, bx_reg, by_reg, r_reg;
    logic [63:0]        ax_full, ay_full, bx_full, by_full;

    assign busy = 1'b0;

    always_comb
    begin
        ax_full = start_x - center_x;
        ay_full = start_y - center_y;
        bx_full = end_x - center_x;
        by_full = end_y - center_y;

        f1_next.base_ok = (curve_id != 32'd0) && in_span(start_x) && in_span(start_y)
                          && in_span(end_x) && in_span(end_y)
                          && !((start_x == end_x) && (start_y == end_y));
        f1_next.is_line = (curve_kind == KIND_LINE);
        f1_next.is_arc  = (curve_kind == KIND_ARC);
        f1_next.arc_ok  = (radius != 64'd0) && (radius <= SPAN_NM)
                          && in_span(center_x) && in_span(center_y);
        f1_next.ccw     = ccw;
        f1_next.major   = major;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_reg <= f1_next;
        ax_reg <= ax_full[OPW-1:0];
        ay_reg <= ay_full[OPW-1:0];
        bx_reg <= bx_full[OPW-1:0];
        by_reg <= by_full[OPW-1:0];
        r_reg  <= radius[OPW-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 2: 22x22 partial products of every operand pair
    // ------------------------------------------------------------------
    logic signed [OPW-1:0] op_a [NMUL];
    logic signed [OPW-1:0] op_b [NMUL];
    logic signed [HALF:0]  a_lo [NMUL];
    logic signed [HALF:0]  a_hi [NMUL];
    logic signed [HALF:0]  b_lo [NMUL];
    logic signed [HALF:0]  b_hi [NMUL];
    logic signed [PPW-1:0] pp_hh_reg [NMUL];
    logic signed [PPW-1:0] pp_hl_reg [NMUL];
    logic signed [PPW-1:0] pp_lh_reg [NMUL];
    logic signed [PPW-1:0] pp_ll_reg [NMUL];
    logic                  v2_reg;
    flags_t                f2_reg;

    // Route operands to multiplier slots
    always_comb
    begin
        op_a[MUL_AXAX] = ax_reg;  op_b[MUL_AXAX] = ax_reg;
        op_a[MUL_AYAY] = ay_reg;  op_b[MUL_AYAY] = ay_reg;
        op_a[MUL_BXBX] = bx_reg;  op_b[MUL_BXBX] = bx_reg;
        op_a[MUL_BYBY] = by_reg;  op_b[MUL_BYBY] = by_reg;
        op_a[MUL_RR]   = r_reg;   op_b[MUL_RR]   = r_reg;
        op_a[MUL_AXBY] = ax_reg;  op_b[MUL_AXBY] = by_reg;
        op_a[MUL_AYBX] = ay_reg;  op_b[MUL_AYBX] = bx_reg;
        op_a[MUL_AXBX] = ax_reg;  op_b[MUL_AXBX] = bx_reg;
        op_a[MUL_AYBY] = ay_reg;  op_b[MUL_AYBY] = by_reg;
    end

    // Split each operand: unsigned low half, signed high half
    always_comb
    begin
        for (int i = 0; i < NMUL; i++)
        begin
            a_lo[i] = {1'b0, op_a[i][HALF-1:0]};
            a_hi[i] = {op_a[i][OPW-1], op_a[i][OPW-1:HALF]};
            b_lo[i] = {1'b0, op_b[i][HALF-1:0]};
            b_hi[i] = {op_b[i][OPW-1], op_b[i][OPW-1:HALF]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NMUL; i++)
        begin
            pp_hh_reg[i] <= a_hi[i] * b_hi[i];
            pp_hl_reg[i] <= a_hi[i] * b_lo[i];
            pp_lh_reg[i] <= a_lo[i] * b_hi[i];
            pp_ll_reg[i] <= a_lo[i] * b_lo[i];
        end
        f2_reg <= f1_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: combine partial products into full products
    // ------------------------------------------------------------------
    logic signed [MIDW-1:0] mid_sum [NMUL];
    logic signed [PW-1:0]   prod_reg [NMUL];
    logic                   v3_reg;
    flags_t                 f3_reg;

    always_comb
    begin
        for (int i = 0; i < NMUL; i++)
        begin
            mid_sum[i] = MIDW'(pp_hl_reg[i]) + MIDW'(pp_lh_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NMUL; i++)
        begin
            prod_reg[i] <= (PW'(pp_hh_reg[i]) <<< (2 * HALF))
                         + (PW'(mid_sum[i]) <<< HALF)
                         + PW'(pp_ll_reg[i]);
        end
        f3_reg <= f2_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: circle errors, cross and dot products
    // ------------------------------------------------------------------
    logic signed [PW-1:0] err_a_reg, err_b_reg, cross_reg, dot_reg;
    logic                 v4_reg;
    flags_t               f4_reg;

    always_ff @(posedge clk)
    begin
        err_a_reg <= prod_reg[MUL_AXAX] + prod_reg[MUL_AYAY] - prod_reg[MUL_RR];
        err_b_reg <= prod_reg[MUL_BXBX] + prod_reg[MUL_BYBY] - prod_reg[MUL_RR];
        cross_reg <= prod_reg[MUL_AXBY] - prod_reg[MUL_AYBX];
        dot_reg   <= prod_reg[MUL_AXBX] + prod_reg[MUL_AYBY];
        f4_reg    <= f3_reg;
    end

    // Advance the valid bits down the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: final decision into the output register
    // ------------------------------------------------------------------
    logic done_reg;
    logic valid_res_reg;
    logic valid_res_next;
    logic on_circle, cr_pos, cr_neg, or_pos, or_neg, dot_neg;

    always_comb
    begin
        on_circle = (err_a_reg == '0) && (err_b_reg == '0);
        cr_neg    = cross_reg[PW-1];
        cr_pos    = !cross_reg[PW-1] && (cross_reg != '0);
        or_pos    = f4_reg.ccw ? cr_pos : cr_neg;
        or_neg    = f4_reg.ccw ? cr_neg : cr_pos;
        dot_neg   = dot_reg[PW-1];

        priority if (!f4_reg.base_ok)
            valid_res_next = 1'b0;
        else if (f4_reg.is_line)
            valid_res_next = 1'b1;
        else if (!f4_reg.is_arc || !f4_reg.arc_ok || !on_circle)
            valid_res_next = 1'b0;
        else if (!or_pos && !or_neg)
            valid_res_next = !f4_reg.major && dot_neg;
        else
            valid_res_next = f4_reg.major ? or_neg : or_pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        valid_res_reg <= valid_res_next;
    end

    assign done      = done_reg;
    assign valid_res = valid_res_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##5 done)
        else $error("accepted word did not complete after five edges");

    a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 5))
        else $error("done without a word accepted five edges earlier");

    a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (curve_id == 32'd0)) |-> ##5 !valid_res)
        else $error("curve with zero index passed");

    a_bad_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (curve_kind != KIND_LINE) && (curve_kind != KIND_ARC))
        |-> ##5 !valid_res)
        else $error("curve of unknown kind passed");

endmodule
